FILE: rtl/pfb_pkg.sv
package pfb_pkg;

  // Widths of the item fields and configuration registers
  localparam int unsigned CmdW    = 2;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned RdAddrW = 9;
  localparam int unsigned ColW    = 7;
  localparam int unsigned RowW    = 6;
  localparam int unsigned PageW   = 4;
  localparam int unsigned OffW    = 3;

  // Command codes
  typedef enum logic [CmdW-1:0] {
    CMD_BLIT  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  // Placement of one blit word, handed from the address unit to the sequencer
  typedef struct packed {
    logic            write_top;  // top page is on the display
    logic            aligned;    // row offset inside the page is zero
    logic            second;     // next page exists for an unaligned word
    logic            clip;       // part of the word is dropped
    logic            done;       // last word of the bitmap
    logic [OffW-1:0] off;        // row offset inside the top page
  } blit_plan_t;

endpackage

FILE: rtl/pfb_blit_calc.sv
module pfb_blit_calc #(
  parameter int unsigned COLUMNS = 84,
  parameter int unsigned PAGES   = 6
) (
  input  logic [pfb_pkg::ColW-1:0]              origin_x_i,
  input  logic [pfb_pkg::RowW-1:0]              origin_y_i,
  input  logic [pfb_pkg::ColW-1:0]              width_cols_i,
  input  logic [pfb_pkg::RowW-1:0]              height_rows_i,
  input  logic [pfb_pkg::ColW-1:0]              col_cur_i,
  input  logic [pfb_pkg::RowW-1:0]              row_cur_i,
  output pfb_pkg::blit_plan_t                   plan_o,
  output logic [$clog2(COLUMNS*PAGES)-1:0]      at_o,
  output logic [pfb_pkg::ColW-1:0]              col_next_o,
  output logic [pfb_pkg::RowW-1:0]              row_next_o
);

  localparam int unsigned AddrW = $clog2(COLUMNS * PAGES);
  localparam logic [8:0]  ColsLim  = 9'(COLUMNS);
  localparam logic [5:0]  PagesLim = 6'(PAGES);

  logic [pfb_pkg::ColW:0]    col_sum;
  logic [pfb_pkg::RowW:0]    row_sum;
  logic [pfb_pkg::PageW-1:0] page;
  logic [pfb_pkg::OffW-1:0]  off;
  logic                      col_ok, page_ok, next_ok;
  logic [pfb_pkg::ColW:0]    col_inc;
  logic [pfb_pkg::RowW:0]    row_inc;
  logic                      wrap, last;

  // Display position of the cursor
  assign col_sum = {1'b0, origin_x_i} + {1'b0, col_cur_i};
  assign row_sum = {1'b0, origin_y_i} + {1'b0, row_cur_i};
  assign page    = row_sum[pfb_pkg::RowW:pfb_pkg::OffW];
  assign off     = row_sum[pfb_pkg::OffW-1:0];

  // Range checks against the display
  assign col_ok  = {1'b0, col_sum} < ColsLim;
  assign page_ok = {2'b0, page} < PagesLim;
  assign next_ok = ({2'b0, page} + 6'd1) < PagesLim;

  // Byte index, meaningful only when on the display
  assign at_o = AddrW'((32'(page) * 32'(COLUMNS)) + 32'(col_sum));

  always_comb begin
    plan_o.write_top = col_ok && page_ok;
    plan_o.aligned   = (off == '0);
    plan_o.second    = next_ok;
    plan_o.clip      = !(col_ok && page_ok) || ((off != '0) && !next_ok);
    plan_o.done      = last;
    plan_o.off       = off;
  end

  // Cursor walk: across columns, then down one page of rows
  assign col_inc = {1'b0, col_cur_i} + 8'd1;
  assign row_inc = {1'b0, row_cur_i} + 7'd8;
  assign wrap    = col_inc >= {1'b0, width_cols_i};
  assign last    = wrap && (row_inc >= {1'b0, height_rows_i});

  always_comb begin
    col_next_o = wrap ? '0 : col_inc[pfb_pkg::ColW-1:0];
    row_next_o = row_cur_i;
    if (wrap) begin
      row_next_o = last ? '0 : row_inc[pfb_pkg::RowW-1:0];
    end
  end

endmodule

FILE: rtl/paged_framebuffer_blitter.sv
// Channel  | handshake                      | payload
// ---------+--------------------------------+-----------------------------------------
// input    | in_valid_i / in_ready_o        | command_i, pixel_byte_i, read_address_i
// output   | out_valid_o / out_ready_i      | read_data_o, blit_done_o, clipped_o
// config   | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// One single-port store with a registered read sets the steps per word:
// aligned or fully clipped blit, no-op and out-of-range read end in S_IDLE;
// a read adds S_READ; an unaligned blit adds S_TOP (top page only), or S_TOP,
// S_LOW_RD, S_LOW_WR (read-modify-write of both pages). Clear and reset sweep
// all COLUMNS*PAGES bytes (504 by default) in S_CLEAR before in_ready_o rises.
// A result waits in the output register; a finished word that meets a full
// output register holds the sequencer until the register drains.
module paged_framebuffer_blitter #(
  parameter int unsigned COLUMNS = 84,
  parameter int unsigned PAGES   = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input words
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pfb_pkg::CmdW-1:0]      command_i,
  input  logic [pfb_pkg::ByteW-1:0]     pixel_byte_i,
  input  logic [pfb_pkg::RdAddrW-1:0]   read_address_i,
  // result words
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pfb_pkg::ByteW-1:0]     read_data_o,
  output logic                          blit_done_o,
  output logic                          clipped_o,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int unsigned Store = COLUMNS * PAGES;
  localparam int unsigned AddrW = $clog2(Store);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Store - 1);
  localparam logic [AddrW-1:0] PageStep = AddrW'(COLUMNS);

  typedef enum logic [1:0] {
    REG_ORIGIN_X    = 2'd0,
    REG_ORIGIN_Y    = 2'd1,
    REG_WIDTH_COLS  = 2'd2,
    REG_HEIGHT_ROWS = 2'd3
  } reg_e;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_READ   = 7'b0000010,
    S_TOP    = 7'b0000100,
    S_LOW_RD = 7'b0001000,
    S_LOW_WR = 7'b0010000,
    S_CLEAR  = 7'b0100000,
    S_HOLD   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [pfb_pkg::ColW-1:0] origin_x_q, width_cols_q, col_cur_q, col_next;
  logic [pfb_pkg::RowW-1:0] origin_y_q, height_rows_q, row_cur_q, row_next;

  pfb_pkg::blit_plan_t plan;
  logic [AddrW-1:0]    blit_at;

  // Operation registers
  logic [AddrW-1:0]          at_q;
  logic [pfb_pkg::OffW-1:0]  off_q;
  logic [pfb_pkg::ByteW-1:0] byte_q;
  logic                      second_q;
  logic [AddrW-1:0]          clr_q;
  logic                      clr_res_q;
  logic [pfb_pkg::ByteW-1:0] res_data_q;
  logic                      res_done_q, res_clip_q;

  // Store
  logic [pfb_pkg::ByteW-1:0] frame_mem_q [Store];
  logic [pfb_pkg::ByteW-1:0] mem_rdata_q;
  logic                      mem_we;
  logic [AddrW-1:0]          mem_addr;
  logic [pfb_pkg::ByteW-1:0] mem_wdata;

  logic                      out_valid_q;
  logic [pfb_pkg::ByteW-1:0] out_data_q;
  logic                      out_done_q, out_clip_q;

  logic                      accept, is_blit, is_read, is_clear, rd_ok;
  logic                      fin, slot_free;
  logic [pfb_pkg::ByteW-1:0] fin_data;
  logic                      fin_done, fin_clip;
  logic [pfb_pkg::ByteW-1:0] low_mask;
  logic [pfb_pkg::ByteW-1:0] top_merge, low_merge;
  logic [3:0]                up_shift;
  logic                      cfg_wr;

  assign accept   = in_valid_i && in_ready_o;
  assign is_blit  = (command_i == pfb_pkg::CMD_BLIT);
  assign is_read  = (command_i == pfb_pkg::CMD_READ);
  assign is_clear = (command_i == pfb_pkg::CMD_CLEAR);
  assign rd_ok    = 32'(read_address_i) < 32'(Store);

  assign in_ready_o = (state_q == S_IDLE);
  assign slot_free  = !out_valid_q || out_ready_i;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q    <= '0;
      origin_y_q    <= '0;
      width_cols_q  <= 7'd84;
      height_rows_q <= 6'd48;
    end else if (cfg_wr) begin
      unique case (reg_e'(paddr[3:2]))
        REG_ORIGIN_X:    origin_x_q    <= pwdata[pfb_pkg::ColW-1:0];
        REG_ORIGIN_Y:    origin_y_q    <= pwdata[pfb_pkg::RowW-1:0];
        REG_WIDTH_COLS:  width_cols_q  <= pwdata[pfb_pkg::ColW-1:0];
        REG_HEIGHT_ROWS: height_rows_q <= pwdata[pfb_pkg::RowW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_e'(paddr[3:2]))
      REG_ORIGIN_X:    prdata = 32'(origin_x_q);
      REG_ORIGIN_Y:    prdata = 32'(origin_y_q);
      REG_WIDTH_COLS:  prdata = 32'(width_cols_q);
      REG_HEIGHT_ROWS: prdata = 32'(height_rows_q);
      default:         prdata = '0;
    endcase
  end

  // Placement and cursor walk
  pfb_blit_calc #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES)
  ) u_calc (
    .origin_x_i   (origin_x_q),
    .origin_y_i   (origin_y_q),
    .width_cols_i (width_cols_q),
    .height_rows_i(height_rows_q),
    .col_cur_i    (col_cur_q),
    .row_cur_i    (row_cur_q),
    .plan_o       (plan),
    .at_o         (blit_at),
    .col_next_o   (col_next),
    .row_next_o   (row_next)
  );

  // Merge of the shifted word into the two pages
  assign low_mask  = ~(8'hFF << off_q);
  assign up_shift  = 4'd8 - {1'b0, off_q};
  assign top_merge = (mem_rdata_q & low_mask) | (byte_q << off_q);
  assign low_merge = (mem_rdata_q & ~low_mask) | ((byte_q >> up_shift) & low_mask);

  // Store port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = at_q;
    mem_wdata = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept && is_blit) begin
          mem_addr  = blit_at;
          mem_we    = plan.write_top && plan.aligned;
          mem_wdata = pixel_byte_i;
        end else if (accept && is_read) begin
          mem_addr = AddrW'(read_address_i);
        end
      end
      S_TOP: begin
        mem_we    = 1'b1;
        mem_wdata = top_merge;
      end
      S_LOW_RD: mem_addr = at_q + PageStep;
      S_LOW_WR: begin
        mem_we    = 1'b1;
        mem_addr  = at_q + PageStep;
        mem_wdata = low_merge;
      end
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
      end
      S_READ, S_HOLD: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_mem_q[mem_addr] <= mem_wdata;
    end
    mem_rdata_q <= frame_mem_q[mem_addr];
  end

  // Result ready this cycle, and its value
  always_comb begin
    fin      = 1'b0;
    fin_data = res_data_q;
    fin_done = res_done_q;
    fin_clip = res_clip_q;
    unique case (state_q)
      S_IDLE: begin
        fin      = accept && !is_clear
                   && !(is_blit && plan.write_top && !plan.aligned)
                   && !(is_read && rd_ok);
        fin_data = '0;
        fin_done = is_blit && plan.done;
        fin_clip = (is_blit && plan.clip) || (is_read && !rd_ok);
      end
      S_READ: begin
        fin      = 1'b1;
        fin_data = mem_rdata_q;
      end
      S_TOP:    fin = !second_q;
      S_LOW_WR: fin = 1'b1;
      S_CLEAR:  fin = clr_res_q && (clr_q == LastAddr);
      S_HOLD:   fin = 1'b1;
      S_LOW_RD: ;
      default: ;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    if (fin) begin
      state_d = slot_free ? S_IDLE : S_HOLD;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (is_clear) begin
              state_d = S_CLEAR;
            end else if (is_read) begin
              state_d = S_READ;
            end else begin
              state_d = S_TOP;
            end
          end
        end
        S_TOP:    state_d = S_LOW_RD;
        S_LOW_RD: state_d = S_LOW_WR;
        S_CLEAR:  state_d = (clr_q == LastAddr) ? S_IDLE : S_CLEAR;
        S_READ, S_LOW_WR, S_HOLD: ;
        default: state_d = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      clr_res_q <= 1'b0;
      col_cur_q <= '0;
      row_cur_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + AddrW'(1);
        if (clr_q == LastAddr) begin
          clr_res_q <= clr_res_q && !slot_free;
        end
      end
      if (accept && is_clear) begin
        clr_q     <= '0;
        clr_res_q <= 1'b1;
        col_cur_q <= '0;
        row_cur_q <= '0;
      end else if (accept && is_blit) begin
        col_cur_q <= col_next;
        row_cur_q <= row_next;
      end
      if (state_q == S_HOLD && slot_free) begin
        clr_res_q <= 1'b0;
      end
    end
  end

  // Operation and pending-result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      at_q     <= blit_at;
      off_q    <= plan.off;
      byte_q   <= pixel_byte_i;
      second_q <= plan.second;
    end
    if (fin) begin
      res_data_q <= fin_data;
      res_done_q <= fin_done;
      res_clip_q <= fin_clip;
    end else if (accept) begin
      res_data_q <= '0;
      res_done_q <= is_blit && plan.done;
      res_clip_q <= is_blit && plan.clip;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin && slot_free) begin
      out_data_q <= fin_data;
      out_done_q <= fin_done;
      out_clip_q <= fin_clip;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;
  assign blit_done_o = out_done_q;
  assign clipped_o   = out_clip_q;

`ifndef SYNTHESIS
  // A clear holds off the next word for the whole sweep
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_clear |=> !in_ready_o)
    else $error("word accepted right after a clear");

  // Every store write lands inside the store
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (32'(mem_addr) < 32'(Store)))
    else $error("store write out of range");

  // The lower page is written only right after its read
  a_low_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOW_WR |-> $past(state_q) == S_LOW_RD)
    else $error("lower page written without its read");
`endif

endmodule
